>>> design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 BMP decoder
// Holds the transaction payloads, the result record passed from the grouping
// logic to the output register, and the code point constants.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam logic [15:0] REPLACEMENT_CP = 16'hFFFD;
	localparam logic [15:0] NONCHAR_CP     = 16'hFFFF;

	// Upper bounds of the lead byte ranges.
	localparam logic [7:0] LEAD_ONE_MAX   = 8'h7F;
	localparam logic [7:0] LEAD_TWO_MAX   = 8'hDF;
	localparam logic [7:0] LEAD_THREE_MAX = 8'hEF;

	// Group kinds.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_TWO   = 2'd1;
	localparam logic [1:0] KIND_THREE = 2'd2;
	localparam logic [1:0] KIND_SKIP  = 2'd3;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_point;
		logic        text_done;
	} out_item_t;

	// Result of decoding one byte, handed to the output register.
	typedef struct packed {
		logic        valid;
		out_item_t   item;
	} dec_res_t;

	// Grouping state, visible to the top level for checking.
	typedef struct packed {
		logic [1:0] group_kind;
		logic [1:0] bytes_taken;
	} grp_status_t;

endpackage

>>> design/u8d_stream_if.sv
// ----------------------------------------------------------------------------
// u8d_stream_if: valid/ready stream channel
// Carries one payload of type payload_t per transaction.
// ----------------------------------------------------------------------------
interface u8d_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> design/u8d_in_stage.sv
// ----------------------------------------------------------------------------
// u8d_in_stage: input register
// Captures one byte per transaction and holds it until the grouping logic
// consumes it.
// ----------------------------------------------------------------------------
module u8d_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  u8d_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              valid_s1,
	output u8d_pkg::in_item_t item_s1
);
	import u8d_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> design/u8d_group_fsm.sv
// ----------------------------------------------------------------------------
// u8d_group_fsm: byte grouping state and code point assembly
// Tracks the open group and decides, for the byte in the input register,
// whether it closes a group and what code point results.
// ----------------------------------------------------------------------------
module u8d_group_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  u8d_pkg::in_item_t    item_s1,
	output u8d_pkg::dec_res_t    res,
	output u8d_pkg::grp_status_t status
);
	import u8d_pkg::*;

	logic [1:0]  group_kind_q, group_kind_d;
	logic [1:0]  bytes_taken_q, bytes_taken_d;
	logic [7:0]  lead_byte_q, lead_byte_d;
	logic [7:0]  middle_byte_q, middle_byte_d;
	logic [7:0]  b;
	logic        fin;
	logic [15:0] cp_three;

	assign b   = item_s1.byte_value;
	assign fin = item_s1.end_of_text;
	assign cp_three = {lead_byte_q[3:0], middle_byte_q[5:0], b[5:0]};

	always_comb begin
		group_kind_d  = group_kind_q;
		bytes_taken_d = bytes_taken_q;
		lead_byte_d   = lead_byte_q;
		middle_byte_d = middle_byte_q;
		res.valid           = 1'b0;
		res.item.code_point = {8'd0, b};
		res.item.text_done  = fin;
		case (group_kind_q)
			KIND_NONE: begin
				if (b <= LEAD_ONE_MAX) begin
					res.valid = 1'b1;
				end else begin
					if (b <= LEAD_TWO_MAX) begin
						group_kind_d = KIND_TWO;
					end else if (b <= LEAD_THREE_MAX) begin
						group_kind_d = KIND_THREE;
					end else begin
						group_kind_d = KIND_SKIP;
					end
					bytes_taken_d = 2'd1;
					lead_byte_d   = b;
					// A lead byte that ends the text is a truncated group.
					if (fin) begin
						group_kind_d  = KIND_NONE;
						bytes_taken_d = 2'd0;
						lead_byte_d   = 8'd0;
						res.valid           = 1'b1;
						res.item.code_point = REPLACEMENT_CP;
					end
				end
			end
			KIND_TWO: begin
				group_kind_d  = KIND_NONE;
				bytes_taken_d = 2'd0;
				lead_byte_d   = 8'd0;
				middle_byte_d = 8'd0;
				res.valid           = 1'b1;
				res.item.code_point = {5'd0, lead_byte_q[4:0], b[5:0]};
			end
			KIND_THREE: begin
				if (bytes_taken_q < 2'd2) begin
					middle_byte_d = b;
					bytes_taken_d = 2'd2;
					if (fin) begin
						group_kind_d  = KIND_NONE;
						bytes_taken_d = 2'd0;
						lead_byte_d   = 8'd0;
						middle_byte_d = 8'd0;
						res.valid           = 1'b1;
						res.item.code_point = REPLACEMENT_CP;
					end
				end else begin
					group_kind_d  = KIND_NONE;
					bytes_taken_d = 2'd0;
					lead_byte_d   = 8'd0;
					middle_byte_d = 8'd0;
					res.valid           = 1'b1;
					res.item.code_point = (cp_three == NONCHAR_CP) ? REPLACEMENT_CP
						: cp_three;
				end
			end
			default: begin
				// Four-byte group: skipped and replaced as a whole.
				if (bytes_taken_q == 2'd3 || fin) begin
					group_kind_d  = KIND_NONE;
					bytes_taken_d = 2'd0;
					lead_byte_d   = 8'd0;
					middle_byte_d = 8'd0;
					res.valid           = 1'b1;
					res.item.code_point = REPLACEMENT_CP;
				end else begin
					bytes_taken_d = bytes_taken_q + 2'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_kind_q  <= KIND_NONE;
			bytes_taken_q <= 2'd0;
			lead_byte_q   <= 8'd0;
			middle_byte_q <= 8'd0;
		end else if (advance) begin
			group_kind_q  <= group_kind_d;
			bytes_taken_q <= bytes_taken_d;
			lead_byte_q   <= lead_byte_d;
			middle_byte_q <= middle_byte_d;
		end
	end

	assign status.group_kind  = group_kind_q;
	assign status.bytes_taken = bytes_taken_q;

endmodule

>>> design/u8d_out_reg.sv
// ----------------------------------------------------------------------------
// u8d_out_reg: result register
// Holds one decoded code point until the downstream side takes it, and
// accepts a new one in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module u8d_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  u8d_pkg::dec_res_t  res,
	output logic               can_take,
	output logic               out_valid,
	input  logic               out_ready,
	output u8d_pkg::out_item_t out_item
);
	import u8d_pkg::*;

	logic      valid_s2;
	out_item_t item_s2;

	assign can_take = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_take) begin
			valid_s2 <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && advance && res.valid) begin
			item_s2 <= res.item;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

>>> design/utf8_bmp_decoder_core.sv
// Path: a byte that closes a group is held in the input register, and its code
// point is registered in the result register and given out from there.
// Throughput: one byte per cycle, set by the single grouping register set that
// each byte updates once; a result left waiting stalls the input as soon as
// the input register also holds a byte.
// Reset: arst_n clears the grouping state and both valid flags at once.
// ----------------------------------------------------------------------------
// utf8_bmp_decoder_core: streaming UTF-8 decoder for the Basic Multilingual Plane
// Groups bytes by their lead byte and gives one 16-bit code point per group,
// with 0xFFFD for four-byte groups, 0xFFFF and truncated groups.
// ----------------------------------------------------------------------------
module utf8_bmp_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	u8d_stream_if.sink          in_ch,
	u8d_stream_if.source        out_ch
);
	import u8d_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        advance;
	logic        can_take;
	dec_res_t    res;
	grp_status_t status;

	assign advance = valid_s1 && can_take;

	u8d_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_item  (in_ch.payload),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	u8d_group_fsm u_group_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.res     (res),
		.status  (status)
	);

	u8d_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res       (res),
		.can_take  (can_take),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_item  (out_ch.payload)
	);

	// An open group always has at least its lead byte counted.
	a_open_group_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(status.group_kind == KIND_NONE) == (status.bytes_taken == 2'd0))
		else $error("group state and byte count disagree");

	// A two-byte group is only ever open right after its lead byte.
	a_two_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		(status.group_kind == KIND_TWO) |-> (status.bytes_taken == 2'd1))
		else $error("two-byte group holds a wrong byte count");

	// The final byte of a text always closes with a result marked done.
	a_final_byte_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.end_of_text) |-> (res.valid && res.item.text_done))
		else $error("final byte did not produce a done result");

	// The noncharacter 0xFFFF is never delivered.
	a_no_nonchar: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.item.code_point != NONCHAR_CP))
		else $error("noncharacter code point produced");

endmodule
